// ===== rtl/ising_pkg.sv =====
package ising_pkg;

  localparam int ROW_W  = 6;
  localparam int SIDE_W = 7;
  localparam int THR_W  = 17;
  localparam int RND_W  = 16;
  localparam int DE_W   = 5;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W  = 3;

  localparam int DEF_MAX_SIDE = 64;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Remainder steps for a row or column index, one index bit per step.
  localparam int RED_STEPS = ROW_W;
  localparam int CNT_W     = $clog2(RED_STEPS + 1);

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR4 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR8 = 2'd2;

  typedef enum logic [2:0] {
    ADR_CTR,
    ADR_RP,
    ADR_RM,
    ADR_CP,
    ADR_CM
  } adr_sel_e;

  typedef struct packed {
    logic     capture;
    logic     step;
    logic     rd_en;
    adr_sel_e adr_sel;
    logic     wr_load;
    logic     cap_ctr;
    logic     acc;
    logic     decide;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic            red_done;
    logic [OP_W-1:0] op;
  } sts_t;

endpackage

// ===== rtl/ising_ram.sv =====
module ising_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ising_ctrl.sv =====
module ising_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ising_pkg::sts_t sts_i,
  output ising_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_CTR,
    S_RP,
    S_RM,
    S_CP,
    S_CM,
    S_DEC,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.adr_sel = ising_pkg::ADR_CTR;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.step = 1'b1;
        if (sts_i.red_done) begin
          if (sts_i.op == ising_pkg::OP_LOAD) begin
            cmd_o.wr_load = 1'b1;
            state_d       = S_FIN;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_CTR;
          end
        end
      end
      S_CTR: begin
        cmd_o.cap_ctr = 1'b1;
        if (sts_i.op == ising_pkg::OP_UPDATE) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.adr_sel = ising_pkg::ADR_RP;
          state_d       = S_RP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RP: begin
        cmd_o.acc     = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.adr_sel = ising_pkg::ADR_RM;
        state_d       = S_RM;
      end
      S_RM: begin
        cmd_o.acc     = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.adr_sel = ising_pkg::ADR_CP;
        state_d       = S_CP;
      end
      S_CP: begin
        cmd_o.acc     = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.adr_sel = ising_pkg::ADR_CM;
        state_d       = S_CM;
      end
      S_CM: begin
        cmd_o.acc = 1'b1;
        state_d   = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ising_dp.sv =====
module ising_dp #(
  parameter int MAX_SIDE = ising_pkg::DEF_MAX_SIDE
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ising_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ising_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [ising_pkg::OP_W-1:0]            op_i,
  input  logic [ising_pkg::ROW_W-1:0]           row_i,
  input  logic [ising_pkg::ROW_W-1:0]           col_i,
  input  logic                                  spin_in_i,
  input  logic [ising_pkg::RND_W-1:0]           random_fraction_i,
  input  ising_pkg::cmd_t                       cmd_i,
  output ising_pkg::sts_t                       sts_o,
  output logic                                  spin_out_o,
  output logic                                  flipped_o,
  output logic signed [ising_pkg::DE_W-1:0]     energy_change_o
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int NW    = $clog2(MAX_SIDE + 1);
  localparam int XW    = (NW > ising_pkg::SIDE_W) ? NW : ising_pkg::SIDE_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = ising_pkg::ROW_W;

  // Configuration registers.
  logic [ising_pkg::SIDE_W-1:0] side_q;
  logic [ising_pkg::THR_W-1:0]  thr4_q, thr8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= ising_pkg::SIDE_RESET;
      thr4_q <= '0;
      thr8_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ising_pkg::CFG_SIDE: side_q <= cfg_data_i[ising_pkg::SIDE_W-1:0];
        ising_pkg::CFG_THR4: thr4_q <= cfg_data_i[ising_pkg::THR_W-1:0];
        ising_pkg::CFG_THR8: thr8_q <= cfg_data_i[ising_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Side in use, clamped to the legal range.
  logic [XW-1:0] side_x, n_x, row_x, col_x;
  logic [NW-1:0] n;
  logic          in_range;

  always_comb begin
    side_x = XW'(side_q);
    if (side_x < XW'(2)) begin
      n_x = XW'(2);
    end else if (side_x > XW'(MAX_SIDE)) begin
      n_x = XW'(MAX_SIDE);
    end else begin
      n_x = side_x;
    end
  end

  assign n        = n_x[NW-1:0];
  assign row_x    = XW'(row_i);
  assign col_x    = XW'(col_i);
  assign in_range = (row_x < n_x) && (col_x < n_x);

  // Item registers and the bit-serial remainder lanes.
  logic [ising_pkg::OP_W-1:0]  op_q;
  logic                        spin_q;
  logic [ising_pkg::RND_W-1:0] rnd_q;
  logic [NW-1:0]               rrem_q, crem_q;
  logic [RW-1:0]               rsh_q, csh_q;
  logic [ising_pkg::CNT_W-1:0] cnt_q;

  logic [NW:0]   rtry, ctry, rsub, csub, n_ext;
  logic [NW-1:0] rrem_step, crem_step;

  assign n_ext     = {1'b0, n};
  assign rtry      = {rrem_q, rsh_q[RW-1]};
  assign ctry      = {crem_q, csh_q[RW-1]};
  assign rsub      = rtry - n_ext;
  assign csub      = ctry - n_ext;
  assign rrem_step = (rtry >= n_ext) ? rsub[NW-1:0] : rtry[NW-1:0];
  assign crem_step = (ctry >= n_ext) ? csub[NW-1:0] : ctry[NW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.capture) begin
      cnt_q <= in_range ? '0 : ising_pkg::CNT_W'(ising_pkg::RED_STEPS);
    end else if (cmd_i.step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - ising_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      spin_q <= spin_in_i;
      rnd_q  <= random_fraction_i;
      rsh_q  <= row_i;
      csh_q  <= col_i;
      if (in_range) begin
        rrem_q <= row_x[NW-1:0];
        crem_q <= col_x[NW-1:0];
      end else begin
        rrem_q <= '0;
        crem_q <= '0;
      end
    end else if (cmd_i.step && (cnt_q != '0)) begin
      rrem_q <= rrem_step;
      crem_q <= crem_step;
      rsh_q  <= {rsh_q[RW-2:0], 1'b0};
      csh_q  <= {csh_q[RW-2:0], 1'b0};
    end
  end

  assign sts_o.red_done = (cnt_q == '0);
  assign sts_o.op       = op_q;

  // Neighbor coordinates with toroidal wrap.
  logic [NW-1:0] r_inc, c_inc, r_p, r_m, c_p, c_m, sel_r, sel_c;
  logic [AW-1:0] addr;

  assign r_inc = rrem_q + NW'(1);
  assign c_inc = crem_q + NW'(1);
  assign r_p   = (r_inc == n) ? '0 : r_inc;
  assign c_p   = (c_inc == n) ? '0 : c_inc;
  assign r_m   = (rrem_q == '0) ? (n - NW'(1)) : (rrem_q - NW'(1));
  assign c_m   = (crem_q == '0) ? (n - NW'(1)) : (crem_q - NW'(1));

  always_comb begin
    sel_r = rrem_q;
    sel_c = crem_q;
    case (cmd_i.adr_sel)
      ising_pkg::ADR_RP: sel_r = r_p;
      ising_pkg::ADR_RM: sel_r = r_m;
      ising_pkg::ADR_CP: sel_c = c_p;
      ising_pkg::ADR_CM: sel_c = c_m;
      default: ;
    endcase
  end

  assign addr = AW'(sel_r[CW-1:0]) * AW'(MAX_SIDE) + AW'(sel_c[CW-1:0]);

  // Energy change and acceptance.
  logic                            center_q, flip_q;
  logic [ising_pkg::SUM_W-1:0]     sum_q;
  logic signed [ising_pkg::DE_W-1:0] de_q, de;
  logic [ising_pkg::DE_W-1:0]      ones4;
  logic [ising_pkg::THR_W-1:0]     rnd_x;
  logic                            accept;
  logic                            rd_data, we, wdata;

  assign ones4 = {sum_q, 2'b00};
  assign de    = center_q ? $signed(ones4 - 5'd8) : $signed(5'd8 - ones4);
  assign rnd_x = {1'b0, rnd_q};
  assign accept = (de <= 5'sd0)
               || ((de == 5'sd4) && (rnd_x < thr4_q))
               || ((de == 5'sd8) && (rnd_x < thr8_q));

  assign we    = cmd_i.wr_load | (cmd_i.decide & accept);
  assign wdata = cmd_i.wr_load ? spin_q : ~center_q;

  ising_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_ctr) begin
      center_q <= rd_data;
      sum_q    <= '0;
      flip_q   <= 1'b0;
      de_q     <= '0;
    end else if (cmd_i.wr_load) begin
      center_q <= spin_q;
      flip_q   <= 1'b0;
      de_q     <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + ising_pkg::SUM_W'(rd_data);
    end else if (cmd_i.decide) begin
      center_q <= center_q ^ accept;
      flip_q   <= accept;
      de_q     <= de;
    end
  end

  // Output register.
  logic                              spin_out_q, flipped_q;
  logic signed [ising_pkg::DE_W-1:0] de_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      spin_out_q <= center_q;
      flipped_q  <= flip_q;
      de_out_q   <= de_q;
    end
  end

  assign spin_out_o      = spin_out_q;
  assign flipped_o       = flipped_q;
  assign energy_change_o = de_out_q;

endmodule

// ===== rtl/ising_metropolis_spin_update.sv =====
// From input transfer to result, a load passes REDUCE and FIN, a read REDUCE, CTR
// and FIN, and an update REDUCE, CTR, RP, RM, CP, CM, DEC and FIN. An index at or
// above the side in use takes the bit-serial remainder steps in REDUCE. A new
// item is taken only in IDLE; the lattice RAM has one read port, one site per cycle.
// Reset (rst_ni, asynchronous, active low) clears control and configuration;
// the lattice RAM keeps its contents and must be loaded before use.
module ising_metropolis_spin_update #(
  parameter int MAX_SIDE = ising_pkg::DEF_MAX_SIDE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ising_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ising_pkg::CFG_W-1:0]       cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ising_pkg::OP_W-1:0]        op_i,
  input  logic [ising_pkg::ROW_W-1:0]       row_i,
  input  logic [ising_pkg::ROW_W-1:0]       col_i,
  input  logic                              spin_in_i,
  input  logic [ising_pkg::RND_W-1:0]       random_fraction_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              spin_out_o,
  output logic                              flipped_o,
  output logic signed [ising_pkg::DE_W-1:0] energy_change_o
);

  // The controller sequences each operation: it reduces the site indices
  // modulo the side in use. A load writes the spin and a read fetches the center;
  // an update reads the center and four neighbors from the lattice RAM one per
  // cycle, decides the flip and writes back. The result sits in an output
  // register, so a new transfer is taken while an earlier result still waits.
  ising_pkg::cmd_t cmd;
  ising_pkg::sts_t sts;

  ising_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the index remainder lanes, the
  // neighbor address logic, the lattice RAM and the acceptance test.
  ising_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .spin_in_i         (spin_in_i),
    .random_fraction_i (random_fraction_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .spin_out_o        (spin_out_o),
    .flipped_o         (flipped_o),
    .energy_change_o   (energy_change_o)
  );

endmodule
